>>> design/bloom_gradient_mesh_forwarder_assert.svh
// assertion macros for the bloom gradient mesh forwarder
// used by files that check their own control logic; needs clk and rst in scope
`ifndef BLOOM_GRADIENT_MESH_FORWARDER_ASSERT_SVH
`define BLOOM_GRADIENT_MESH_FORWARDER_ASSERT_SVH

// same-cycle implication
`define BGMF_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bgmf check failed");

// next-cycle implication
`define BGMF_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bgmf check failed");

`endif

>>> design/bgmf_pkg.sv
// shared types, constants and hash function of the bloom gradient mesh forwarder
// no dependencies
package bgmf_pkg;

  localparam int NEIGHBORS = 16;
  localparam int SLOT_W    = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;

  // operation codes
  localparam logic [1:0] OP_ANNOUNCE = 2'd0;
  localparam logic [1:0] OP_DATA     = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;

  // result status codes
  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_FORWARD = 3'd1;
  localparam logic [2:0] ST_NO_BEST = 3'd2;
  localparam logic [2:0] ST_OWN     = 3'd3;
  localparam logic [2:0] ST_HOPS    = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_TICK    = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_OWN_ID  = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_MAXHOPS = 2'd2;

  localparam logic [31:0] HASH_MUL = 32'd1103515245;
  localparam logic [18:0] LCG_INC  = 19'd12345;

  // one neighbor table entry
  typedef struct packed {
    logic        valid;
    logic [31:0] node;
    logic [63:0] bloom;
    logic [31:0] seen;
  } entry_t;

  // counter index of an id: bits 18..16 of the lcg step
  function automatic logic [2:0] hash_index(input logic [31:0] id);
    logic [18:0] p;
    p = id[18:0] * HASH_MUL[18:0] + LCG_INC;
    return p[18:16];
  endfunction

endpackage

>>> design/bloom_gradient_mesh_forwarder.sv
// top level of the bloom gradient mesh forwarder: controller and cell chain
// depends on bgmf_pkg, bgmf_cell and bloom_gradient_mesh_forwarder_assert.svh
//
//   channel  | handshake             | payload
//   input    | in_valid / in_ready   | op src_node bloom degrade_index dst_id hops now_ms
//   output   | out_valid / out_ready | status neighbor_slot neighbor_id next_hops
//            |                       | own_bloom_out last
//   config   | cfg_we                | cfg_index cfg_data
//
// the table rotates through the cell chain one entry per cycle; the head is examined
// tick items take one rotation, data items a hash step and one rotation
// announcements take a merge step and two rotations (find slot, then write)
// one item at a time; a full output register stalls the forward rotation
// reset empties the table and own bloom and loads register defaults
`include "bloom_gradient_mesh_forwarder_assert.svh"

module bloom_gradient_mesh_forwarder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] src_node,
  input  logic [63:0] bloom,
  input  logic [2:0]  degrade_index,
  input  logic [31:0] dst_id,
  input  logic [7:0]  hops,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  neighbor_slot,
  output logic [31:0] neighbor_id,
  output logic [7:0]  next_hops,
  output logic [63:0] own_bloom_out,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int N = bgmf_pkg::NEIGHBORS;
  localparam int SW = bgmf_pkg::SLOT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(N - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MERGE = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_HASH  = 3'd4;
  localparam logic [2:0] S_FWD   = 3'd5;
  localparam logic [2:0] S_TICK  = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  // configuration
  logic [31:0] own_id;
  logic [15:0] timeout_ms;
  logic [7:0]  max_hops;
  logic [2:0]  own_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id     <= 32'd0;
      timeout_ms <= 16'd5000;
      max_hops   <= 8'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        bgmf_pkg::CFG_OWN_ID:  own_id     <= cfg_data;
        bgmf_pkg::CFG_TIMEOUT: timeout_ms <= cfg_data[15:0];
        bgmf_pkg::CFG_MAXHOPS: max_hops   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // id bloom position, registered after the multiply
  always_ff @(posedge clk) begin
    own_h <= bgmf_pkg::hash_index(own_id);
  end

  // cell chain: head at cell 0, feed enters the tail
  bgmf_pkg::entry_t cell_q [N];
  bgmf_pkg::entry_t feed;
  bgmf_pkg::entry_t head;
  logic             shift;

  for (genvar i = 0; i < N; i++) begin : g_cell
    bgmf_pkg::entry_t din;
    if (i == N - 1) begin : g_tail
      assign din = feed;
    end else begin : g_mid
      assign din = cell_q[i + 1];
    end
    bgmf_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .shift(shift),
      .din  (din),
      .dout (cell_q[i])
    );
  end

  assign head = cell_q[0];

  // controller state and item registers
  logic [2:0]    state, state_next;
  logic [SW-1:0] cnt;
  logic [31:0]   sender_r, dst_r, now_r;
  logic [63:0]   bloom_r;
  logic [2:0]    di_r, dst_h;
  logic [7:0]    hop_r;
  logic [63:0]   own_bloom;
  logic          found_v, free_v;
  logic [SW-1:0] found_s, free_s, tgt_r;
  logic          pend_valid;
  logic [2:0]    resp_status;
  logic [3:0]    resp_slot;
  logic [31:0]   resp_id;
  logic [7:0]    resp_hops;

  logic can_load, accept, at_end;
  assign can_load = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign at_end   = (cnt == LAST_SLOT);

  // merged own bloom: max of own, degraded announcement and id bloom
  logic [63:0] merged;
  always_comb begin
    logic [7:0] a, d;
    for (int i = 0; i < 8; i++) begin
      a = own_bloom[8*i +: 8];
      d = bloom_r[8*i +: 8];
      if (3'(i) == di_r && d != 8'd0) d = d - 8'd1;
      merged[8*i +: 8] = (3'(i) == own_h) ? 8'hFF : ((a > d) ? a : d);
    end
  end

  // head tests
  logic        match, qual, expired;
  logic [7:0]  head_c, nh;
  assign match   = head.valid && (head.node == sender_r);
  assign head_c  = head.bloom[8*dst_h +: 8];
  assign qual    = head.valid && (dst_h != own_h) && (head_c != 8'd0);
  assign expired = (now_r - head.seen) > {16'd0, timeout_ms};
  assign nh      = (hop_r == 8'hFF) ? 8'hFF : hop_r + 8'd1;

  // slot search including the current head
  logic          tgt_v;
  logic [SW-1:0] tgt;
  always_comb begin
    tgt_v = 1'b1;
    tgt   = found_s;
    if (!found_v) begin
      if (match) begin
        tgt = cnt;
      end else if (free_v) begin
        tgt = free_s;
      end else if (!head.valid) begin
        tgt = cnt;
      end else begin
        tgt_v = 1'b0;
      end
    end
  end

  // forward stage holds when a pending result cannot leave
  logic fwd_stall;
  assign fwd_stall = qual && pend_valid && !can_load;

  // shift, tail feed and next state
  always_comb begin
    state_next = state;
    shift      = 1'b0;
    feed       = head;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            bgmf_pkg::OP_ANNOUNCE:
              state_next = (src_node == own_id) ? S_RESP : S_MERGE;
            bgmf_pkg::OP_DATA:
              state_next = (src_node == own_id || hops > max_hops) ? S_RESP : S_HASH;
            bgmf_pkg::OP_TICK: state_next = S_TICK;
            default:           state_next = S_IDLE;
          endcase
        end
      end
      S_MERGE: state_next = S_SCAN;
      S_SCAN: begin
        shift = 1'b1;
        if (at_end) state_next = tgt_v ? S_WRITE : S_RESP;
      end
      S_WRITE: begin
        shift = 1'b1;
        if (cnt == tgt_r) begin
          feed.valid = 1'b1;
          feed.node  = sender_r;
          feed.bloom = bloom_r;
          feed.seen  = now_r;
        end
        if (at_end) state_next = S_RESP;
      end
      S_HASH: state_next = S_FWD;
      S_FWD: begin
        shift = !fwd_stall;
        if (at_end && !fwd_stall) state_next = S_RESP;
      end
      S_TICK: begin
        shift = 1'b1;
        if (head.valid && expired) feed.valid = 1'b0;
        if (at_end) state_next = S_RESP;
      end
      S_RESP: begin
        if (can_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      own_bloom  <= 64'd0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      found_v    <= 1'b0;
      free_v     <= 1'b0;
    end else begin
      state <= state_next;
      if (shift) cnt <= at_end ? '0 : cnt + SW'(1);
      if (state == S_MERGE) begin
        own_bloom <= merged;
        found_v   <= 1'b0;
        free_v    <= 1'b0;
      end
      if (state == S_SCAN) begin
        if (!found_v && match) found_v <= 1'b1;
        if (!free_v && !head.valid) free_v <= 1'b1;
      end
      if (state == S_FWD && qual && !fwd_stall) pend_valid <= 1'b1;
      if (state == S_RESP && can_load) pend_valid <= 1'b0;
      if ((state == S_FWD && qual && pend_valid && can_load) ||
          (state == S_RESP && can_load)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item fields, search results and pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      sender_r <= src_node;
      bloom_r  <= bloom;
      di_r     <= degrade_index;
      dst_r    <= dst_id;
      hop_r    <= hops;
      now_r    <= now_ms;
      resp_slot <= 4'd0;
      resp_id   <= 32'd0;
      resp_hops <= 8'd0;
      if (src_node == own_id) resp_status <= bgmf_pkg::ST_OWN;
      else resp_status <= bgmf_pkg::ST_HOPS;
    end
    if (state == S_SCAN) begin
      if (!found_v && match) found_s <= cnt;
      if (!free_v && !head.valid) free_s <= cnt;
      if (at_end) begin
        tgt_r <= tgt;
        if (!tgt_v) resp_status <= bgmf_pkg::ST_FULL;
      end
    end
    if (state == S_WRITE && at_end) begin
      resp_status <= bgmf_pkg::ST_STORED;
      resp_slot   <= 4'(tgt_r);
      resp_id     <= sender_r;
    end
    if (state == S_HASH) dst_h <= bgmf_pkg::hash_index(dst_r);
    if (state == S_FWD && !fwd_stall) begin
      if (qual) begin
        resp_status <= bgmf_pkg::ST_FORWARD;
        resp_slot   <= 4'(cnt);
        resp_id     <= head.node;
        resp_hops   <= nh;
      end else if (at_end && !pend_valid) begin
        resp_status <= bgmf_pkg::ST_NO_BEST;
      end
    end
    if (state == S_TICK && at_end) resp_status <= bgmf_pkg::ST_TICK;
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_FWD && qual && pend_valid && can_load) begin
      status        <= resp_status;
      neighbor_slot <= resp_slot;
      neighbor_id   <= resp_id;
      next_hops     <= resp_hops;
      own_bloom_out <= own_bloom;
      last          <= 1'b0;
    end else if (state == S_RESP && can_load) begin
      status        <= resp_status;
      neighbor_slot <= resp_slot;
      neighbor_id   <= resp_id;
      next_hops     <= resp_hops;
      own_bloom_out <= own_bloom;
      last          <= 1'b1;
    end
  end

  `BGMF_CHECK(a_home_when_idle, state == S_IDLE, cnt == '0)
  `BGMF_CHECK(a_idle_out_last, state == S_IDLE && out_valid, last)
  `BGMF_CHECK(a_pend_scope, pend_valid, state == S_FWD || state == S_RESP)
  `BGMF_CHECK_NEXT(a_resp_leaves, state == S_RESP && can_load, state == S_IDLE)

endmodule

>>> design/bgmf_cell.sv
// one neighbor table cell of the rotating entry chain
// depends on bgmf_pkg
module bgmf_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  bgmf_pkg::entry_t din,
  output bgmf_pkg::entry_t dout
);

  logic        valid;
  logic [31:0] node;
  logic [63:0] bloom;
  logic [31:0] seen;

  // valid bit is control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= din.valid;
    end
  end

  // payload moves with the chain
  always_ff @(posedge clk) begin
    if (shift) begin
      node  <= din.node;
      bloom <= din.bloom;
      seen  <= din.seen;
    end
  end

  assign dout = {valid, node, bloom, seen};

endmodule

>>> tb/tb_bloom_gradient_mesh_forwarder.sv
// testbench of the bloom gradient mesh forwarder: table, merge, forwarding and expiry
// needs bgmf_pkg and bloom_gradient_mesh_forwarder; predicts every result in-line
module tb_bloom_gradient_mesh_forwarder;

  localparam logic [1:0] OP_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = bgmf_pkg::OP_TICK;
  logic [31:0] src_node = '0;
  logic [63:0] bloom = '0;
  logic [2:0]  degrade_index = '0;
  logic [31:0] dst_id = '0;
  logic [7:0]  hops = '0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [3:0]  neighbor_slot;
  logic [31:0] neighbor_id;
  logic [7:0]  next_hops;
  logic [63:0] own_bloom_out;
  logic        last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = bgmf_pkg::CFG_OWN_ID;
  logic [31:0] cfg_data = '0;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] id;
    logic [7:0]  hops;
    logic [63:0] own;
    logic        last;
  } route_t;

  route_t route_q[$];

  // predicted state
  logic [31:0] m_own_id;
  logic [15:0] m_timeout;
  logic [7:0]  m_max_hops;
  logic        m_valid[bgmf_pkg::NEIGHBORS];
  logic [31:0] m_node[bgmf_pkg::NEIGHBORS];
  logic [63:0] m_bloom[bgmf_pkg::NEIGHBORS];
  logic [31:0] m_seen[bgmf_pkg::NEIGHBORS];
  logic [63:0] m_own_bloom;

  int errors = 0;
  int results_seen = 0;
  int forwards_seen = 0;
  int fulls_seen = 0;
  int rx_idle = 0;
  bit idle_on = 1'b1;
  bit hold_rx = 1'b0;
  logic [31:0] clock_ms = 32'd1000;

  bloom_gradient_mesh_forwarder DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [2:0] lcg_index(input logic [31:0] id);
    logic [63:0] x;
    x = {32'd0, id} * 64'd1103515245 + 64'd12345;
    return 3'(((x / 64'd65536) % 64'd32768) % 64'd8);
  endfunction

  function automatic logic [63:0] counter_max(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    for (int i = 0; i < 8; i++)
      r[8*i +: 8] = (a[8*i +: 8] > b[8*i +: 8]) ? a[8*i +: 8] : b[8*i +: 8];
    return r;
  endfunction

  function automatic route_t mk(input logic [2:0] st, input logic [3:0] sl,
                                input logic [31:0] id, input logic [7:0] h, input logic l);
    route_t r;
    r.status = st; r.slot = sl; r.id = id; r.hops = h; r.own = m_own_bloom; r.last = l;
    return r;
  endfunction

  // work out the results of one item and update the predicted state
  task automatic predict_routes(input logic [1:0] o, input logic [31:0] snd,
                                input logic [63:0] bl, input logic [2:0] di,
                                input logic [31:0] dst, input logic [7:0] hp,
                                input logic [31:0] now);
    logic [63:0] deg;
    logic [2:0]  h;
    logic [7:0]  own_c, nh;
    int found, free_s, k;
    route_t pend[$];
    found = -1; free_s = -1;
    if (o == bgmf_pkg::OP_ANNOUNCE) begin
      if (snd == m_own_id) begin
        route_q.push_back(mk(bgmf_pkg::ST_OWN, 0, 0, 0, 1'b1));
        return;
      end
      deg = bl;
      if (bl[8*di +: 8] != 0) deg[8*di +: 8] = bl[8*di +: 8] - 8'd1;
      m_own_bloom = counter_max(m_own_bloom, 64'hFF << (8 * lcg_index(m_own_id)));
      m_own_bloom = counter_max(m_own_bloom, deg);
      for (int s = 0; s < bgmf_pkg::NEIGHBORS; s++) begin
        if (m_valid[s]) begin
          if (found < 0 && m_node[s] == snd) found = s;
        end else if (free_s < 0) begin
          free_s = s;
        end
      end
      if (found < 0) found = free_s;
      if (found < 0) begin
        route_q.push_back(mk(bgmf_pkg::ST_FULL, 0, 0, 0, 1'b1));
        return;
      end
      m_valid[found] = 1'b1; m_node[found] = snd; m_bloom[found] = bl; m_seen[found] = now;
      route_q.push_back(mk(bgmf_pkg::ST_STORED, 4'(found), snd, 0, 1'b1));
    end else if (o == bgmf_pkg::OP_DATA) begin
      if (snd == m_own_id) begin
        route_q.push_back(mk(bgmf_pkg::ST_OWN, 0, 0, 0, 1'b1));
        return;
      end
      if (hp > m_max_hops) begin
        route_q.push_back(mk(bgmf_pkg::ST_HOPS, 0, 0, 0, 1'b1));
        return;
      end
      nh = (hp < 8'd255) ? hp + 8'd1 : 8'd255;
      h = lcg_index(dst);
      own_c = (h == lcg_index(m_own_id)) ? 8'd255 : 8'd0;
      for (int s = 0; s < bgmf_pkg::NEIGHBORS; s++)
        if (m_valid[s] && m_bloom[s][8*h +: 8] > own_c)
          pend.push_back(mk(bgmf_pkg::ST_FORWARD, 4'(s), m_node[s], nh, 1'b0));
      k = pend.size();
      if (k == 0) begin
        route_q.push_back(mk(bgmf_pkg::ST_NO_BEST, 0, 0, 0, 1'b1));
        return;
      end
      pend[k-1].last = 1'b1;
      foreach (pend[i]) route_q.push_back(pend[i]);
    end else if (o == bgmf_pkg::OP_TICK) begin
      for (int s = 0; s < bgmf_pkg::NEIGHBORS; s++)
        if (m_valid[s] && (now - m_seen[s]) > {16'd0, m_timeout}) m_valid[s] = 1'b0;
      route_q.push_back(mk(bgmf_pkg::ST_TICK, 0, 0, 0, 1'b1));
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
  endtask

  // send one item, predicting its results at acceptance
  task automatic send_item(input logic [1:0] o, input logic [31:0] snd,
                           input logic [63:0] bl, input logic [2:0] di,
                           input logic [31:0] dst, input logic [7:0] hp,
                           input logic [31:0] now);
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(posedge clk);
    in_valid <= 1'b1; op <= o; src_node <= snd; bloom <= bl; degrade_index <= di;
    dst_id <= dst; hops <= hp; now_ms <= now;
    do @(posedge clk); while (!in_ready);
    predict_routes(o, snd, bl, di, dst, hp, now);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (route_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bgmf_pkg::CFG_OWN_ID:  m_own_id = val;
      bgmf_pkg::CFG_TIMEOUT: m_timeout = val[15:0];
      bgmf_pkg::CFG_MAXHOPS: m_max_hops = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // output handshake: random idle bursts plus an optional long hold
  always @(posedge clk) begin
    if (rst || hold_rx) begin
      out_ready <= 1'b0;
    end else if (!idle_on) begin
      out_ready <= 1'b1;
    end else if (rx_idle > 0) begin
      rx_idle   <= rx_idle - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      rx_idle   <= $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      route_t w;
      results_seen++;
      if (route_q.size() == 0) begin
        report("unexpected result status", status, 64'd0);
      end else begin
        w = route_q.pop_front();
        if (status == bgmf_pkg::ST_FORWARD) forwards_seen++;
        if (status == bgmf_pkg::ST_FULL) fulls_seen++;
        if (status !== w.status) report("status", status, w.status);
        if (neighbor_slot !== w.slot) report("neighbor_slot", neighbor_slot, w.slot);
        if (neighbor_id !== w.id) report("neighbor_id", neighbor_id, w.id);
        if (next_hops !== w.hops) report("next_hops", next_hops, w.hops);
        if (own_bloom_out !== w.own) report("own_bloom_out", own_bloom_out, w.own);
        if (last !== w.last) report("last", last, w.last);
      end
    end
  end

  function automatic logic [63:0] rand_bloom();
    logic [63:0] b;
    b = {$urandom, $urandom};
    for (int i = 0; i < 8; i++)
      case ($urandom_range(0, 3))
        0: b[8*i +: 8] = 8'd0;
        1: b[8*i +: 8] = 8'd255;
        default: ;
      endcase
    return b;
  endfunction

  // sender ids come from a small pool so entries get refreshed and matched
  function automatic logic [31:0] pool_id();
    return ($urandom_range(0, 9) == 0) ? $urandom : 32'h100 + $urandom_range(0, 21);
  endfunction

  task automatic test_directed();
    clock_ms = 32'd1000;
    send_item(bgmf_pkg::OP_TICK, 0, 0, 0, 0, 0, clock_ms);
    send_item(bgmf_pkg::OP_DATA, 32'd5, 0, 0, 32'd7, 8'd0, clock_ms);
    send_item(bgmf_pkg::OP_ANNOUNCE, 32'd0, '1, 3'd0, 0, 0, clock_ms);
    send_item(bgmf_pkg::OP_DATA, 32'd0, 0, 0, 0, 0, clock_ms);
    send_item(bgmf_pkg::OP_ANNOUNCE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 0, 0,
              clock_ms);
    send_item(bgmf_pkg::OP_ANNOUNCE, 32'd1, 64'h0000_0000_0000_0000, 3'd3, 0, 0, clock_ms);
    send_item(bgmf_pkg::OP_ANNOUNCE, 32'd2, 64'h0102_0304_0506_0700, 3'd0, 0, 0, clock_ms);
    send_item(bgmf_pkg::OP_ANNOUNCE, 32'd1, 64'h8000_0000_0000_0001, 3'd0, 0, 0, clock_ms);
    send_item(bgmf_pkg::OP_DATA, 32'd9, 0, 0, 32'hFFFF_FFFF, 8'd200, clock_ms);
    send_item(bgmf_pkg::OP_DATA, 32'd9, 0, 0, 32'd0, 8'd201, clock_ms);
    send_item(bgmf_pkg::OP_DATA, 32'd9, 0, 0, 32'd1, 8'd255, clock_ms);
    send_item(OP_NONE, 32'd9, '1, 3'd7, '1, 8'd255, '1);
    send_item(bgmf_pkg::OP_TICK, 0, 0, 0, 0, 0, clock_ms + 32'd5000);
    send_item(bgmf_pkg::OP_TICK, 0, 0, 0, 0, 0, clock_ms + 32'd5001);
    send_item(bgmf_pkg::OP_TICK, 0, 0, 0, 0, 0, clock_ms - 32'd7);
    wait_drained();
    write_reg(bgmf_pkg::CFG_MAXHOPS, 32'd255);
    send_item(bgmf_pkg::OP_DATA, 32'd9, 0, 0, 32'd3, 8'd255, clock_ms);
    wait_drained();
  endtask

  // fill all slots, then two more announcements hit the full table
  task automatic test_table_full();
    write_reg(bgmf_pkg::CFG_TIMEOUT, 32'd65535);
    for (int i = 0; i < bgmf_pkg::NEIGHBORS + 2; i++)
      send_item(bgmf_pkg::OP_ANNOUNCE, 32'h200 + i, rand_bloom(), 3'($urandom), 0, 0,
                clock_ms);
    send_item(bgmf_pkg::OP_DATA, 32'd9, 0, 0, $urandom, 8'd3, clock_ms);
    wait_drained();
    write_reg(bgmf_pkg::CFG_TIMEOUT, 32'd0);
    clock_ms += 32'd1;
    send_item(bgmf_pkg::OP_TICK, 0, 0, 0, 0, 0, clock_ms);
    wait_drained();
  endtask

  // long receiver hold while items keep coming, then the sender waits out all results
  task automatic test_backpressure();
    write_reg(bgmf_pkg::CFG_TIMEOUT, 32'd5000);
    for (int i = 0; i < 10; i++)
      send_item(bgmf_pkg::OP_ANNOUNCE, 32'h300 + i, '1, 3'($urandom), 0, 0, clock_ms);
    wait_drained();
    hold_rx = 1'b1;
    fork
      begin
        int n;
        for (n = 0; n < 300; n++) @(posedge clk);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send_item(bgmf_pkg::OP_DATA, 32'd9, 0, 0, $urandom, 8'd1, clock_ms);
    join
    wait_drained();
  endtask

  task automatic test_random(input int count);
    logic [1:0] o;
    logic [31:0] cfg;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 59) begin
        wait_drained();
        case ($urandom_range(0, 2))
          0: cfg = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
          1: cfg = $urandom;
          default: cfg = 32'h100 + $urandom_range(0, 21);
        endcase
        write_reg(bgmf_pkg::CFG_OWN_ID, cfg);
        write_reg(bgmf_pkg::CFG_TIMEOUT, $urandom_range(0, 1) ? $urandom_range(0, 65535)
                              : ($urandom_range(0, 1) ? 32'd0 : 32'd65535));
        write_reg(bgmf_pkg::CFG_MAXHOPS, $urandom_range(0, 255));
      end
      if (i > count - 60) idle_on = 1'b0;
      clock_ms += $urandom_range(0, 1500);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: o = bgmf_pkg::OP_ANNOUNCE;
        4, 5, 6, 7: o = bgmf_pkg::OP_DATA;
        8: o = bgmf_pkg::OP_TICK;
        default: o = ($urandom_range(0, 3) == 0) ? OP_NONE : bgmf_pkg::OP_DATA;
      endcase
      send_item(o, ($urandom_range(0, 15) == 0) ? m_own_id : pool_id(), rand_bloom(),
                3'($urandom), $urandom,
                ($urandom_range(0, 1)) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 8)),
                ($urandom_range(0, 30) == 0) ? $urandom : clock_ms);
    end
    wait_drained();
  endtask

  initial begin
    m_own_id = 32'd0; m_timeout = 16'd5000; m_max_hops = 8'd200; m_own_bloom = '0;
    for (int s = 0; s < bgmf_pkg::NEIGHBORS; s++) begin
      m_valid[s] = 1'b0; m_node[s] = '0; m_bloom[s] = '0; m_seen[s] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (40) @(posedge clk);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random(320);
    $display("covered announcements, forwarding, hop and sender drops, expiry, full table");
    $display("results checked: %0d, forwards: %0d, full-table: %0d",
             results_seen, forwards_seen, fulls_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/bgmf_pkg.sv
design/bgmf_cell.sv
design/bloom_gradient_mesh_forwarder.sv
tb/tb_bloom_gradient_mesh_forwarder.sv
